>>> hw/rtl/mgbbc_pkg.sv
`default_nettype none
package mgbbc_pkg;

  localparam int BLOCK_W    = 6;
  localparam int BLOCK_H    = 12;
  localparam int COORD_BITS = 12;

  localparam int LEFT_W   = 12;
  localparam int EDGE_W   = 13;
  localparam int PITCH_W  = 13;
  localparam int COLOR_W  = 16;
  localparam int OFF_W    = 26;
  localparam int ROW_W    = 4;
  localparam int BITS_LO_W = 64;
  localparam int BITS_HI_W = BLOCK_W * BLOCK_H - BITS_LO_W;

  localparam int CALC_W = ((COORD_BITS > EDGE_W) ? COORD_BITS : EDGE_W) + 2;
  localparam int PROD_W = CALC_W + PITCH_W;

  localparam int APB_DW = 32;
  localparam int APB_AW = 5;

  localparam logic [ROW_W-1:0] ROW_LAST = ROW_W'(BLOCK_H - 1);

  typedef enum logic [2:0] {
    CFG_CLIP_LEFT   = 3'd0,
    CFG_CLIP_TOP    = 3'd1,
    CFG_CLIP_RIGHT  = 3'd2,
    CFG_CLIP_BOTTOM = 3'd3,
    CFG_ROW_PITCH   = 3'd4
  } cfg_reg_e;

  typedef struct packed {
    logic [LEFT_W-1:0]  clip_left;
    logic [LEFT_W-1:0]  clip_top;
    logic [EDGE_W-1:0]  clip_right;
    logic [EDGE_W-1:0]  clip_bottom;
    logic [PITCH_W-1:0] row_pitch;
  } cfg_t;

  typedef struct packed {
    logic signed [COORD_BITS-1:0]        x;
    logic signed [COORD_BITS-1:0]        y;
    logic [BLOCK_H-1:0][BLOCK_W-1:0]     glyph;
    logic [COLOR_W-1:0]                  color;
    logic [BLOCK_W-1:0]                  col_mask;
  } item_t;

  typedef struct packed {
    logic signed [CALC_W-1:0]     py;
    logic signed [COORD_BITS-1:0] x;
    logic [BLOCK_W-1:0]           mask;
    logic [COLOR_W-1:0]           color;
    logic [ROW_W-1:0]             row;
    logic                         last;
  } row_req_t;

endpackage
`default_nettype wire

>>> hw/rtl/mgbbc_if.sv
`default_nettype none
interface mgbbc_in_if;
  logic                                   valid;
  logic                                   ready;
  logic signed [mgbbc_pkg::COORD_BITS-1:0] block_x;
  logic signed [mgbbc_pkg::COORD_BITS-1:0] block_y;
  logic [mgbbc_pkg::BITS_LO_W-1:0]         bits_low;
  logic [mgbbc_pkg::BITS_HI_W-1:0]         bits_high;
  logic [mgbbc_pkg::COLOR_W-1:0]           ink_color;

  modport source (output valid, block_x, block_y, bits_low, bits_high, ink_color,
                  input ready);
  modport sink (input valid, block_x, block_y, bits_low, bits_high, ink_color,
                output ready);
endinterface

interface mgbbc_out_if;
  logic                               valid;
  logic                               ready;
  logic signed [mgbbc_pkg::OFF_W-1:0] row_offset;
  logic [mgbbc_pkg::BLOCK_W-1:0]      write_mask;
  logic [mgbbc_pkg::COLOR_W-1:0]      row_color;
  logic [mgbbc_pkg::ROW_W-1:0]        row_number;
  logic                               last_row;

  modport source (output valid, row_offset, write_mask, row_color, row_number, last_row,
                  input ready);
  modport sink (input valid, row_offset, write_mask, row_color, row_number, last_row,
                output ready);
endinterface
`default_nettype wire

>>> hw/rtl/mgbbc_cfg.sv
`default_nettype none
module mgbbc_cfg (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [mgbbc_pkg::APB_AW-1:0]  paddr,
  input  logic [mgbbc_pkg::APB_DW-1:0]  pwdata,
  output logic [mgbbc_pkg::APB_DW-1:0]  prdata,
  output logic                          pready,
  output mgbbc_pkg::cfg_t               cfg_o
);
  import mgbbc_pkg::*;

  cfg_t     cfg_q;
  cfg_t     cfg_d;
  cfg_reg_e sel;
  logic     wr_en;

  assign pready = 1'b1;
  assign sel    = cfg_reg_e'(paddr[APB_AW-1:2]);
  assign wr_en  = psel && penable && pwrite && pready;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      case (sel)
        CFG_CLIP_LEFT:   cfg_d.clip_left   = pwdata[LEFT_W-1:0];
        CFG_CLIP_TOP:    cfg_d.clip_top    = pwdata[LEFT_W-1:0];
        CFG_CLIP_RIGHT:  cfg_d.clip_right  = pwdata[EDGE_W-1:0];
        CFG_CLIP_BOTTOM: cfg_d.clip_bottom = pwdata[EDGE_W-1:0];
        CFG_ROW_PITCH:   cfg_d.row_pitch   = pwdata[PITCH_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (sel)
      CFG_CLIP_LEFT:   prdata = APB_DW'(cfg_q.clip_left);
      CFG_CLIP_TOP:    prdata = APB_DW'(cfg_q.clip_top);
      CFG_CLIP_RIGHT:  prdata = APB_DW'(cfg_q.clip_right);
      CFG_CLIP_BOTTOM: prdata = APB_DW'(cfg_q.clip_bottom);
      CFG_ROW_PITCH:   prdata = APB_DW'(cfg_q.row_pitch);
      default:         prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;
endmodule
`default_nettype wire

>>> hw/rtl/mgbbc_cull.sv
`default_nettype none
module mgbbc_cull (
  input  logic              clk_i,
  input  logic              rst_ni,
  mgbbc_in_if.sink          in_if,
  input  mgbbc_pkg::cfg_t   cfg_i,
  input  logic              take_i,
  output logic              valid_o,
  output mgbbc_pkg::item_t  item_o
);
  import mgbbc_pkg::*;

  logic                     valid_q, valid_d;
  logic                     cull_q, cull_d;
  item_t                    item_q, item_d;
  logic signed [CALC_W-1:0] xs, ys, cls, cts, crs, cbs;
  logic signed [CALC_W-1:0] px [BLOCK_W];

  assign xs  = CALC_W'(in_if.block_x);
  assign ys  = CALC_W'(in_if.block_y);
  assign cls = CALC_W'(cfg_i.clip_left);
  assign cts = CALC_W'(cfg_i.clip_top);
  assign crs = CALC_W'(cfg_i.clip_right);
  assign cbs = CALC_W'(cfg_i.clip_bottom);

  assign valid_o     = valid_q && !cull_q;
  assign in_if.ready = !valid_o || take_i;

  always_comb begin
    item_d       = item_q;
    cull_d       = cull_q;
    valid_d      = valid_q;
    if (in_if.ready) begin
      valid_d = in_if.valid;
    end
    if (in_if.ready && in_if.valid) begin
      item_d.x     = in_if.block_x;
      item_d.y     = in_if.block_y;
      item_d.glyph = {in_if.bits_high, in_if.bits_low};
      item_d.color = in_if.ink_color;
      for (int c = 0; c < BLOCK_W; c++) begin
        item_d.col_mask[c] = (px[c] >= cls) && (px[c] < crs);
      end
      cull_d = (xs + CALC_W'(BLOCK_W) <= cls) || (ys + CALC_W'(BLOCK_H) <= cts) ||
               (xs >= crs) || (ys >= cbs);
    end
  end

  always_comb begin
    for (int c = 0; c < BLOCK_W; c++) begin
      px[c] = xs + CALC_W'(c);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      cull_q  <= 1'b0;
    end else begin
      valid_q <= valid_d;
      cull_q  <= cull_d;
    end
  end

  always_ff @(posedge clk_i) begin
    item_q <= item_d;
  end

  assign item_o = item_q;
endmodule
`default_nettype wire

>>> hw/rtl/mgbbc_rowgen.sv
`default_nettype none
module mgbbc_rowgen (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  mgbbc_pkg::cfg_t      cfg_i,
  input  logic                 valid_i,
  input  mgbbc_pkg::item_t     item_i,
  output logic                 load_ok_o,
  output logic                 valid_o,
  output mgbbc_pkg::row_req_t  req_o,
  input  logic                 ready_i
);
  import mgbbc_pkg::*;

  logic                     busy_q, busy_d;
  logic [ROW_W-1:0]         row_q, row_d;
  item_t                    item_q, item_d;
  logic signed [CALC_W-1:0] py, cts, cbs;
  logic                     row_in;
  logic                     last;

  assign last      = (row_q == ROW_LAST);
  assign load_ok_o = !busy_q || (last && ready_i);

  assign cts    = CALC_W'(cfg_i.clip_top);
  assign cbs    = CALC_W'(cfg_i.clip_bottom);
  assign py     = CALC_W'(item_q.y) + CALC_W'(row_q);
  assign row_in = (py >= cts) && (py < cbs);

  always_comb begin
    busy_d = busy_q;
    row_d  = row_q;
    item_d = item_q;
    if (load_ok_o) begin
      busy_d = valid_i;
      row_d  = '0;
      item_d = item_i;
    end else if (busy_q && ready_i) begin
      row_d = row_q + ROW_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      row_q  <= '0;
    end else begin
      busy_q <= busy_d;
      row_q  <= row_d;
    end
  end

  always_ff @(posedge clk_i) begin
    item_q <= item_d;
  end

  assign valid_o     = busy_q;
  assign req_o.py    = py;
  assign req_o.x     = item_q.x;
  assign req_o.mask  = item_q.glyph[row_q] & item_q.col_mask & {BLOCK_W{row_in}};
  assign req_o.color = item_q.color;
  assign req_o.row   = row_q;
  assign req_o.last  = last;
endmodule
`default_nettype wire

>>> hw/rtl/mgbbc_rowcalc.sv
`default_nettype none
module mgbbc_rowcalc (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  mgbbc_pkg::cfg_t      cfg_i,
  input  logic                 valid_i,
  input  mgbbc_pkg::row_req_t  req_i,
  output logic                 ready_o,
  mgbbc_out_if.source          out_if
);
  import mgbbc_pkg::*;

  logic                         c_valid_q;
  logic signed [PROD_W-1:0]     prod_q;
  row_req_t                     c_req_q;
  logic signed [CALC_W-1:0]     pitch_s;
  logic                         d_ready;
  logic                         d_valid_q;
  logic signed [OFF_W-1:0]      off_q;
  logic [BLOCK_W-1:0]           mask_q;
  logic [COLOR_W-1:0]           color_q;
  logic [ROW_W-1:0]             row_q;
  logic                         last_q;

  assign pitch_s = CALC_W'(cfg_i.row_pitch);
  assign d_ready = !d_valid_q || out_if.ready;
  assign ready_o = !c_valid_q || d_ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      c_valid_q <= 1'b0;
      d_valid_q <= 1'b0;
    end else begin
      if (ready_o) begin
        c_valid_q <= valid_i;
      end
      if (d_ready) begin
        d_valid_q <= c_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      prod_q  <= PROD_W'(req_i.py) * PROD_W'(pitch_s);
      c_req_q <= req_i;
    end
    if (d_ready && c_valid_q) begin
      off_q   <= prod_q[OFF_W-1:0] + OFF_W'(c_req_q.x);
      mask_q  <= c_req_q.mask;
      color_q <= c_req_q.color;
      row_q   <= c_req_q.row;
      last_q  <= c_req_q.last;
    end
  end

  assign out_if.valid      = d_valid_q;
  assign out_if.row_offset = off_q;
  assign out_if.write_mask = mask_q;
  assign out_if.row_color  = color_q;
  assign out_if.row_number = row_q;
  assign out_if.last_row   = last_q;
endmodule
`default_nettype wire

>>> hw/rtl/mono_glyph_block_blit_clip_core.sv
// Path: a taken block passes the cull register, the row sequencer, the product register and the output register.
// Throughput: a visible block yields 12 row writes, one per cycle while the receiver is ready;
//   the row sequencer, which holds one block and steps through its rows, sets that rate.
// A culled block yields nothing and is dropped in the input stage.
// Reset: asynchronous, active low; clears all valid bits and the clip and pitch registers.
`default_nettype none
module mono_glyph_block_blit_clip_core (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  mgbbc_in_if.sink                      in_if,
  mgbbc_out_if.source                   out_if,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [mgbbc_pkg::APB_AW-1:0]  paddr,
  input  logic [mgbbc_pkg::APB_DW-1:0]  pwdata,
  output logic [mgbbc_pkg::APB_DW-1:0]  prdata,
  output logic                          pready
);
  import mgbbc_pkg::*;

  cfg_t     cfg;
  logic     a_valid;
  item_t    a_item;
  logic     gen_load_ok;
  logic     gen_valid;
  row_req_t gen_req;
  logic     calc_ready;

  mgbbc_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  mgbbc_cull u_cull (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .in_if   (in_if),
    .cfg_i   (cfg),
    .take_i  (gen_load_ok),
    .valid_o (a_valid),
    .item_o  (a_item)
  );

  mgbbc_rowgen u_rowgen (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_i     (cfg),
    .valid_i   (a_valid),
    .item_i    (a_item),
    .load_ok_o (gen_load_ok),
    .valid_o   (gen_valid),
    .req_o     (gen_req),
    .ready_i   (calc_ready)
  );

  mgbbc_rowcalc u_rowcalc (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cfg_i   (cfg),
    .valid_i (gen_valid),
    .req_i   (gen_req),
    .ready_o (calc_ready),
    .out_if  (out_if)
  );
endmodule
`default_nettype wire

>>> tb/tb_mono_glyph_block_blit_clip_core.sv
`timescale 1ns / 1ps
module tb_mono_glyph_block_blit_clip_core;
  import mgbbc_pkg::*;

  localparam int CYCLE_LIMIT = 400000;
  localparam int RANDOM_PHASES = 6;
  localparam int PHASE_BLOCKS = 75;

  typedef struct packed {
    logic [OFF_W-1:0]   offset;
    logic [BLOCK_W-1:0] mask;
    logic [COLOR_W-1:0] color;
    logic [ROW_W-1:0]   row;
    logic               last;
  } row_wr_t;

  logic clk_i;
  logic rst_ni;
  logic psel;
  logic penable;
  logic pwrite;
  logic [APB_AW-1:0] paddr;
  logic [APB_DW-1:0] pwdata;
  logic [APB_DW-1:0] prdata;
  logic pready;

  mgbbc_in_if  blk_if ();
  mgbbc_out_if row_if ();

  mono_glyph_block_blit_clip_core u_top (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .in_if   (blk_if),
    .out_if  (row_if),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  cfg_t    win;
  row_wr_t rows_due[$];
  row_wr_t want;
  int      mismatches;
  int      rows_checked;
  int      blocks_sent;
  int      blocks_culled;
  int      windows;
  int      cycle_cnt;
  int      rx_mode;
  int      hold_len;
  bit      hold_req;
  bit      hold_ack;
  int      hold_cnt;
  int      pat_age;
  logic [15:0] stall_pat;

  initial clk_i = 1'b0;
  always #2 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  // row write checker and receiver stall pattern
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (row_if.valid && row_if.ready) begin
        if (rows_due.size() == 0) begin
          $error("unexpected row write: row_number %0d row_offset %0d",
                 row_if.row_number, row_if.row_offset);
          mismatches++;
        end else begin
          want = rows_due.pop_front();
          rows_checked++;
          if (row_if.row_offset !== want.offset) begin
            $error("row_offset: expected %0d, actual %0d",
                   $signed(want.offset), $signed(row_if.row_offset));
            mismatches++;
          end
          if (row_if.write_mask !== want.mask) begin
            $error("write_mask: expected %b, actual %b", want.mask, row_if.write_mask);
            mismatches++;
          end
          if (row_if.row_color !== want.color) begin
            $error("row_color: expected %h, actual %h", want.color, row_if.row_color);
            mismatches++;
          end
          if (row_if.row_number !== want.row) begin
            $error("row_number: expected %0d, actual %0d", want.row, row_if.row_number);
            mismatches++;
          end
          if (row_if.last_row !== want.last) begin
            $error("last_row: expected %b, actual %b", want.last, row_if.last_row);
            mismatches++;
          end
        end
      end
      if (hold_req != hold_ack) begin
        hold_cnt = hold_len;
        hold_ack = hold_req;
      end
      pat_age++;
      if (pat_age >= 16) begin
        pat_age = 0;
        stall_pat = 16'($urandom);
      end else begin
        stall_pat = {stall_pat[14:0], stall_pat[15]};
      end
      if (hold_cnt > 0) begin
        hold_cnt--;
        row_if.ready <= 1'b0;
      end else begin
        case (rx_mode)
          0: row_if.ready <= 1'b1;
          1: row_if.ready <= stall_pat[0] | stall_pat[5];
          default: row_if.ready <= ($urandom_range(0, 2) != 0);
        endcase
      end
    end
  end

  task automatic idle_sender(input int n);
    blk_if.valid <= 1'b0;
    repeat (n) @(posedge clk_i);
  endtask

  task automatic wait_idle();
    blk_if.valid <= 1'b0;
    while (rows_due.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic apb_write_check(input cfg_reg_e idx, input logic [APB_DW-1:0] val);
    logic [APB_DW-1:0] kept;
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= APB_AW'(4 * int'(idx));
    pwdata  <= val;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    case (idx)
      CFG_CLIP_LEFT:   begin win.clip_left   = val[LEFT_W-1:0];  kept = APB_DW'(win.clip_left);   end
      CFG_CLIP_TOP:    begin win.clip_top    = val[LEFT_W-1:0];  kept = APB_DW'(win.clip_top);    end
      CFG_CLIP_RIGHT:  begin win.clip_right  = val[EDGE_W-1:0];  kept = APB_DW'(win.clip_right);  end
      CFG_CLIP_BOTTOM: begin win.clip_bottom = val[EDGE_W-1:0];  kept = APB_DW'(win.clip_bottom); end
      default:         begin win.row_pitch   = val[PITCH_W-1:0]; kept = APB_DW'(win.row_pitch);   end
    endcase
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    if (prdata !== kept) begin
      $error("%s readback: expected %h, actual %h", idx.name(), kept, prdata);
      mismatches++;
    end
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic program_window(input logic [APB_DW-1:0] l, t, r, b, p);
    wait_idle();
    apb_write_check(CFG_CLIP_LEFT, l);
    apb_write_check(CFG_CLIP_TOP, t);
    apb_write_check(CFG_CLIP_RIGHT, r);
    apb_write_check(CFG_CLIP_BOTTOM, b);
    apb_write_check(CFG_ROW_PITCH, p);
    windows++;
  endtask

  // offer one block, hold it until taken, then queue the row writes it must produce
  task automatic send_block(input logic signed [COORD_BITS-1:0] x, y,
                            input logic [BITS_LO_W-1:0] lo, input logic [BITS_HI_W-1:0] hi,
                            input logic [COLOR_W-1:0] color);
    int xi, yi, cl, ct, cr, cb, pitch, py, px, off;
    logic [BLOCK_W*BLOCK_H-1:0] glyph;
    row_wr_t w;
    blk_if.valid     <= 1'b1;
    blk_if.block_x   <= x;
    blk_if.block_y   <= y;
    blk_if.bits_low  <= lo;
    blk_if.bits_high <= hi;
    blk_if.ink_color <= color;
    do @(posedge clk_i); while (!blk_if.ready);
    blocks_sent++;
    xi = int'(x);
    yi = int'(y);
    cl = int'(win.clip_left);
    ct = int'(win.clip_top);
    cr = int'(win.clip_right);
    cb = int'(win.clip_bottom);
    pitch = int'(win.row_pitch);
    glyph = {hi, lo};
    if (xi <= cl - BLOCK_W || yi <= ct - BLOCK_H || xi >= cr || yi >= cb) begin
      blocks_culled++;
    end else begin
      for (int row = 0; row < BLOCK_H; row++) begin
        py = yi + row;
        off = py * pitch + xi;
        w.offset = off[OFF_W-1:0];
        w.mask = '0;
        for (int col = 0; col < BLOCK_W; col++) begin
          px = xi + col;
          if (glyph[row * BLOCK_W + col] && py >= ct && py < cb && px >= cl && px < cr)
            w.mask[col] = 1'b1;
        end
        w.color = color;
        w.row = ROW_W'(row);
        w.last = (row == BLOCK_H - 1);
        rows_due.push_back(w);
      end
    end
  endtask

  task automatic send_random_block();
    int lo_x, hi_x, lo_y, hi_y;
    logic signed [COORD_BITS-1:0] x, y;
    logic [BITS_LO_W-1:0] lo;
    logic [BITS_HI_W-1:0] hi;
    // aim most blocks around the window edges
    lo_x = int'(win.clip_left) - 8;
    hi_x = int'(win.clip_right) + 2;
    lo_y = int'(win.clip_top) - 14;
    hi_y = int'(win.clip_bottom) + 2;
    if (lo_x < -2048) lo_x = -2048;
    if (lo_x > 2047) lo_x = 2047;
    if (hi_x > 2047) hi_x = 2047;
    if (hi_x < lo_x) hi_x = lo_x;
    if (lo_y < -2048) lo_y = -2048;
    if (lo_y > 2047) lo_y = 2047;
    if (hi_y > 2047) hi_y = 2047;
    if (hi_y < lo_y) hi_y = lo_y;
    if ($urandom_range(0, 9) < 2) begin
      x = COORD_BITS'($urandom);
      y = COORD_BITS'($urandom);
    end else begin
      x = COORD_BITS'(lo_x + int'($urandom_range(0, hi_x - lo_x)));
      y = COORD_BITS'(lo_y + int'($urandom_range(0, hi_y - lo_y)));
    end
    if ($urandom_range(0, 4) == 0) begin
      lo = '1;
      hi = '1;
    end else begin
      lo = {$urandom, $urandom};
      hi = BITS_HI_W'($urandom);
    end
    send_block(x, y, lo, hi, COLOR_W'($urandom));
  endtask

  task automatic test_reset_window();
    rx_mode <= 2;
    send_block(-3, -5, '1, '1, 16'h5a5a);
    send_block(0, 0, '1, '1, 16'h0001);
    send_block(-6, -1, '1, '1, 16'h0002);
    send_block(-1, -11, '1, '1, 16'h0003);
    wait_idle();
  endtask

  task automatic test_field_extremes();
    program_window(0, 0, 4096, 4096, 4096);
    send_block(0, 0, '1, '1, 16'hffff);
    send_block(2047, 2047, 64'h1, 8'h00, 16'h0000);
    send_block(-2048, -2048, '1, '1, 16'hffff);
    send_block(-5, -11, '1, '1, 16'h0000);
    send_block(5, 3, 64'h8000_0000_0000_0000, 8'h80, 16'h1234);
    send_block(-2048, 2047, '1, '1, 16'h4321);
    send_block(2047, -2048, '1, '1, 16'h4321);
    send_block(100, 200, 64'haaaa_aaaa_aaaa_aaaa, 8'h55, 16'h8000);
  endtask

  task automatic test_partial_clip();
    program_window(100, 50, 300, 200, 320);
    send_block(97, 100, '1, '1, 16'h1111);
    send_block(297, 100, '1, '1, 16'h2222);
    send_block(150, 45, '1, '1, 16'h3333);
    send_block(150, 195, '1, '1, 16'h4444);
    send_block(95, 39, '1, '1, 16'h5555);
    send_block(94, 100, '1, '1, 16'h6666);
    send_block(300, 100, '1, '1, 16'h7777);
  endtask

  task automatic test_degenerate_windows();
    program_window(4095, 4095, 4096, 4096, 0);
    send_block(2047, 2047, '1, '1, 16'h0f0f);
    program_window(200, 100, 198, 106, 17);
    send_block(196, 100, '1, '1, 16'hf0f0);
    send_block(150, 100, '1, '1, 16'hf0f0);
    program_window(10, 10, 40, 40, 0);
    send_block(12, 12, {$urandom, $urandom}, BITS_HI_W'($urandom), 16'hbeef);
    wait_idle();
  endtask

  task automatic test_backpressure();
    program_window(0, 0, 4096, 4096, 640);
    rx_mode <= 0;
    hold_len <= 300;
    hold_req <= ~hold_req;
    repeat (12) send_random_block();
    // pause until the held rows have all drained
    wait_idle();
  endtask

  task automatic test_random_traffic();
    int burst_left;
    int l, t;
    burst_left = 0;
    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      case (ph % 3)
        0: begin
          l = $urandom_range(0, 1500);
          t = $urandom_range(0, 1500);
          program_window(l, t, l + $urandom_range(6, 700), t + $urandom_range(12, 700),
                         $urandom_range(0, 4096));
        end
        1: program_window($urandom, $urandom, $urandom, $urandom, $urandom);
        default: program_window($urandom_range(0, 40), $urandom_range(0, 40),
                                $urandom_range(4000, 4096), $urandom_range(4000, 4096),
                                ($urandom_range(0, 1) != 0) ? 4096 : $urandom_range(0, 8191));
      endcase
      rx_mode <= (ph + 1) % 3;
      for (int i = 0; i < PHASE_BLOCKS; i++) begin
        if (burst_left == 0) begin
          idle_sender($urandom_range(1, 10));
          burst_left = $urandom_range(1, 12);
        end
        burst_left--;
        send_random_block();
      end
    end
  endtask

  initial begin
    rst_ni = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    blk_if.valid = 1'b0;
    blk_if.block_x = '0;
    blk_if.block_y = '0;
    blk_if.bits_low = '0;
    blk_if.bits_high = '0;
    blk_if.ink_color = '0;
    row_if.ready = 1'b0;
    win = '0;
    mismatches = 0;
    rows_checked = 0;
    blocks_sent = 0;
    blocks_culled = 0;
    windows = 0;
    cycle_cnt = 0;
    rx_mode = 0;
    hold_len = 0;
    hold_req = 1'b0;
    hold_ack = 1'b0;
    hold_cnt = 0;
    pat_age = 0;
    stall_pat = 16'hb3c5;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_reset_window();
    test_field_extremes();
    test_partial_clip();
    test_degenerate_windows();
    test_backpressure();
    test_random_traffic();

    wait_idle();
    repeat (20) @(posedge clk_i);
    $display("Checked %0d row writes from %0d glyph blocks (%0d culled)",
             rows_checked, blocks_sent, blocks_culled);
    $display("over %0d clip window settings, with stalls and gaps on both sides.", windows);
    if (mismatches == 0 && rows_due.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
